// ----- rtl/lsmrb_pkg.sv -----
// Shared constants, types and the arctangent table of the laser scan binner.
`default_nettype none
package lsmrb_pkg;
	// Angular bins; must be a power of two
	localparam int BINS = 1024;
	localparam int BIN_BITS = $clog2(BINS);
	// Output coordinate width
	localparam int COORD_BITS = 16;
	// Stored squared distance
	localparam int DIST_BITS = 24;
	// CORDIC datapath widths and step count
	localparam int CW = 36;
	localparam int ZW = 34;
	localparam int STEPS = 30;
	localparam int STEP_BITS = $clog2(STEPS);
	// CORDIC gain compensation, Q30
	localparam logic [29:0] GAIN_Q30 = 30'd652032874;

	// Configuration register indexes
	localparam logic [1:0] REG_SENSOR_X = 2'd0;
	localparam logic [1:0] REG_SENSOR_Y = 2'd1;
	localparam logic [1:0] REG_SENSOR_RANGE = 2'd2;

	// Command codes
	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;
	// spare code, ignored by the block
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic go;
		logic rot;
	} cordic_cmd_t;

	// Arctangent of 2^-i in binary angle units (2^32 per turn)
	function automatic logic [31:0] atan_at(input logic [STEP_BITS-1:0] i);
		logic [31:0] a;
		case (i)
			5'd0: a = 32'd536870912;
			5'd1: a = 32'd316933406;
			5'd2: a = 32'd167458907;
			5'd3: a = 32'd85004756;
			5'd4: a = 32'd42667331;
			5'd5: a = 32'd21354465;
			5'd6: a = 32'd10680350;
			5'd7: a = 32'd5340245;
			5'd8: a = 32'd2670163;
			5'd9: a = 32'd1335087;
			5'd10: a = 32'd667544;
			5'd11: a = 32'd333772;
			5'd12: a = 32'd166886;
			5'd13: a = 32'd83443;
			5'd14: a = 32'd41722;
			5'd15: a = 32'd20861;
			5'd16: a = 32'd10430;
			5'd17: a = 32'd5215;
			5'd18: a = 32'd2608;
			5'd19: a = 32'd1304;
			5'd20: a = 32'd652;
			5'd21: a = 32'd326;
			5'd22: a = 32'd163;
			5'd23: a = 32'd81;
			5'd24: a = 32'd41;
			5'd25: a = 32'd20;
			5'd26: a = 32'd10;
			5'd27: a = 32'd5;
			5'd28: a = 32'd3;
			5'd29: a = 32'd1;
			default: a = 32'd0;
		endcase
		return a;
	endfunction
endpackage
`default_nettype wire

// ----- rtl/lsmrb_cordic.sv -----
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
`default_nettype none
module lsmrb_cordic (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire lsmrb_pkg::cordic_cmd_t         cmd,
	input  wire logic signed [lsmrb_pkg::CW-1:0] x_in,
	input  wire logic signed [lsmrb_pkg::CW-1:0] y_in,
	input  wire logic signed [lsmrb_pkg::ZW-1:0] z_in,
	output logic                                done,
	output logic signed [lsmrb_pkg::CW-1:0]      x_out,
	output logic signed [lsmrb_pkg::CW-1:0]      y_out,
	output logic signed [lsmrb_pkg::ZW-1:0]      z_out
);
	localparam logic signed [lsmrb_pkg::ZW-1:0] QTR = lsmrb_pkg::ZW'(64'sd1073741824);
	localparam logic signed [lsmrb_pkg::ZW-1:0] HALF = lsmrb_pkg::ZW'(64'sd2147483648);

	logic signed [lsmrb_pkg::CW-1:0] x_q, y_q;
	logic signed [lsmrb_pkg::ZW-1:0] z_q;
	logic [lsmrb_pkg::STEP_BITS-1:0] step_q;
	logic run_q, rot_q, done_q;
	logic ccw;
	logic signed [lsmrb_pkg::CW-1:0] xs, ys;
	logic signed [lsmrb_pkg::ZW-1:0] a;

	// direction of the current micro-rotation
	assign ccw = rot_q ? (z_q >= 0) : (y_q <= 0);
	assign xs = x_q >>> step_q;
	assign ys = y_q >>> step_q;
	assign a = lsmrb_pkg::ZW'({2'b00, lsmrb_pkg::atan_at(step_q)});

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			rot_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.go) begin
				run_q <= 1'b1;
				step_q <= '0;
				rot_q <= cmd.rot;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == lsmrb_pkg::STEP_BITS'(lsmrb_pkg::STEPS - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: quadrant fold on start, then micro-rotations
	always_ff @(posedge clk) begin
		if (cmd.go) begin
			if (!cmd.rot) begin
				if (x_in < 0) begin
					x_q <= -x_in;
					y_q <= -y_in;
					z_q <= HALF;
				end else begin
					x_q <= x_in;
					y_q <= y_in;
					z_q <= '0;
				end
			end else begin
				y_q <= y_in;
				if (z_in > QTR) begin
					x_q <= -x_in;
					z_q <= z_in - HALF;
				end else if (z_in < -QTR) begin
					x_q <= -x_in;
					z_q <= z_in + HALF;
				end else begin
					x_q <= x_in;
					z_q <= z_in;
				end
			end
		end else if (run_q) begin
			if (ccw) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - a;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + a;
			end
		end
	end

	assign done = done_q;
	assign x_out = x_q;
	assign y_out = y_q;
	assign z_out = z_q;

	// assertions
	a_no_go_while_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.go |-> !run_q) else $error("cordic started while running");
	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(run_q)) else $error("done without run");
	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !run_q) else $error("run still set at done");
endmodule
`default_nettype wire

// ----- rtl/lidar_scan_min_range_binner.sv -----
// Top level: bearing binner with per-bin minimum range memory and bin readout.
// Insert holds busy through square, sum, range test, 30-step vectoring CORDIC, bin read and
// bin update; an out-of-range point ends at the range test. Read holds busy through memory
// read, bin check, 12-step square root, rounding, gain multiply, CORDIC start and rotation;
// an empty bin ends at the bin check. The result strobe comes in the first idle cycle; the
// receiver cannot stall. Clear and the post-reset pass empty all 1024 bins.
`default_nettype none
module lidar_scan_min_range_binner (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic [1:0]                           op,
	input  wire logic signed [15:0]                   point_x,
	input  wire logic signed [15:0]                   point_y,
	input  wire logic [9:0]                           read_bin,
	output logic                                      done,
	output logic [9:0]                                bin_number,
	output logic                                      bin_hit,
	output logic [11:0]                               hit_range,
	output logic signed [lsmrb_pkg::COORD_BITS-1:0]   hit_x,
	output logic signed [lsmrb_pkg::COORD_BITS-1:0]   hit_y,
	input  wire logic                                 wr_en,
	input  wire logic [1:0]                           wr_index,
	input  wire logic [15:0]                          wr_data
);
	localparam int BB = lsmrb_pkg::BIN_BITS;
	localparam int DB = lsmrb_pkg::DIST_BITS;
	localparam int CW = lsmrb_pkg::CW;
	localparam int ZW = lsmrb_pkg::ZW;
	localparam int CB = lsmrb_pkg::COORD_BITS;

	typedef enum logic [14:0] {
		ST_CLR  = 15'b000000000000001,
		ST_IDLE = 15'b000000000000010,
		ST_SQ   = 15'b000000000000100,
		ST_SUM  = 15'b000000000001000,
		ST_TST  = 15'b000000000010000,
		ST_VEC  = 15'b000000000100000,
		ST_BRD  = 15'b000000001000000,
		ST_UPD  = 15'b000000010000000,
		ST_RRD  = 15'b000000100000000,
		ST_RCHK = 15'b000001000000000,
		ST_SQRT = 15'b000010000000000,
		ST_GAIN = 15'b000100000000000,
		ST_MUL  = 15'b001000000000000,
		ST_RGO  = 15'b010000000000000,
		ST_ROT  = 15'b100000000000000
	} state_t;

	state_t state_q;

	// configuration
	logic signed [15:0] sx_q, sy_q;
	logic [11:0] srng_q;

	// item registers
	logic signed [16:0] dx_q, dy_q;
	logic [33:0] dx2_q, dy2_q;
	logic [34:0] d2_q;
	logic [23:0] lim_q;
	logic [9:0] rb_q;
	logic oob_q;
	logic [BB-1:0] bin_q;
	logic [BB:0] cnt_q;

	// square root
	logic [DB-1:0] rem_q;
	logic [DB:0] root_q, bit_q;
	logic [DB:0] trial;
	logic [12:0] rng_q;
	logic [42:0] prod_q;

	// memory: {valid, min squared distance}
	logic [DB:0] mem [lsmrb_pkg::BINS];
	logic [DB:0] rdata_q;
	logic [BB-1:0] raddr, waddr;
	logic [DB:0] wdata;
	logic we;

	// CORDIC
	lsmrb_pkg::cordic_cmd_t ccmd;
	logic signed [CW-1:0] cx_in, cy_in, cx_out, cy_out;
	logic signed [ZW-1:0] cz_in, cz_out;
	logic cdone;

	// outputs
	logic done_q, hit_q;
	logic [9:0] num_q;
	logic [11:0] range_q;
	logic signed [CB-1:0] hx_q, hy_q;

	logic [31:0] u, theta;
	logic [32:0] usum;
	logic [BB:0] bin_full;
	logic [BB-1:0] bin_next;
	logic zero_off;
	logic signed [CW-1:0] rx, ry, sumx, sumy;

	function automatic logic signed [CB-1:0] sat(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] hi, lo;
		hi = CW'((64'sd1 <<< (CB - 1)) - 64'sd1);
		lo = -hi - CW'(64'sd1);
		if (v > hi) return CB'(hi);
		else if (v < lo) return CB'(lo);
		else return CB'(v);
	endfunction

	// bin from bearing, rounded to nearest, last half bin wraps to 0
	assign zero_off = (dx_q == 17'sd0) && (dy_q == 17'sd0);
	assign u = zero_off ? 32'h8000_0000 : cz_out[31:0];
	assign usum = {1'b0, u} + 33'(64'd1 << (31 - BB));
	assign bin_full = usum[32:32-BB];
	assign bin_next = bin_full[BB] ? '0 : bin_full[BB-1:0];

	// bin center angle plus a half turn
	assign theta = {BB'(rb_q), {(32 - BB){1'b0}}} ^ 32'h8000_0000;

	// CORDIC command and operands
	always_comb begin
		ccmd.go = (state_q == ST_TST && d2_q <= 35'(lim_q)) || (state_q == ST_RGO);
		ccmd.rot = (state_q == ST_RGO);
		if (state_q == ST_RGO) begin
			cx_in = CW'(prod_q[42:14]);
			cy_in = '0;
			cz_in = ZW'(signed'(theta));
		end else begin
			cx_in = -(CW'(dx_q) <<< 14);
			cy_in = -(CW'(dy_q) <<< 14);
			cz_in = '0;
		end
	end

	lsmrb_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (ccmd),
		.x_in   (cx_in),
		.y_in   (cy_in),
		.z_in   (cz_in),
		.done   (cdone),
		.x_out  (cx_out),
		.y_out  (cy_out),
		.z_out  (cz_out)
	);

	// memory addressing
	always_comb begin
		raddr = (state_q == ST_BRD) ? bin_q : BB'(rb_q);
		waddr = (state_q == ST_CLR) ? cnt_q[BB-1:0] : bin_q;
		wdata = (state_q == ST_CLR) ? '0 : {1'b1, d2_q[DB-1:0]};
		we = (state_q == ST_CLR) ||
			(state_q == ST_UPD && (!rdata_q[DB] || d2_q[DB-1:0] < rdata_q[DB-1:0]));
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// square root trial and point rounding
	assign trial = root_q + bit_q;
	assign rx = (cx_out + CW'(64'sd32768)) >>> 16;
	assign ry = (cy_out + CW'(64'sd32768)) >>> 16;
	assign sumx = rx + CW'(sx_q);
	assign sumy = ry + CW'(sy_q);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q <= '0;
			sy_q <= '0;
			srng_q <= 12'd320;
		end else if (wr_en) begin
			unique case (wr_index)
				lsmrb_pkg::REG_SENSOR_X: sx_q <= signed'(wr_data);
				lsmrb_pkg::REG_SENSOR_Y: sy_q <= signed'(wr_data);
				lsmrb_pkg::REG_SENSOR_RANGE: srng_q <= wr_data[11:0];
				default: ;
			endcase
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == (BB + 1)'(lsmrb_pkg::BINS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start) begin
						unique case (op)
							lsmrb_pkg::OP_CLEAR: begin
								cnt_q <= '0;
								state_q <= ST_CLR;
							end
							lsmrb_pkg::OP_INSERT: state_q <= ST_SQ;
							lsmrb_pkg::OP_READ: state_q <= ST_RRD;
							default: ;
						endcase
					end
				end
				ST_SQ: state_q <= ST_SUM;
				ST_SUM: state_q <= ST_TST;
				ST_TST: state_q <= (d2_q > 35'(lim_q)) ? ST_IDLE : ST_VEC;
				ST_VEC: if (cdone) state_q <= ST_BRD;
				ST_BRD: state_q <= ST_UPD;
				ST_UPD: state_q <= ST_IDLE;
				ST_RRD: state_q <= ST_RCHK;
				ST_RCHK: begin
					if (!rdata_q[DB] || oob_q) begin
						done_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: if (bit_q[1:0] != 2'b00) state_q <= ST_GAIN;
				ST_GAIN: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_RGO;
				ST_RGO: state_q <= ST_ROT;
				ST_ROT: begin
					if (cdone) begin
						done_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			dx_q <= 17'(point_x) - 17'(sx_q);
			dy_q <= 17'(point_y) - 17'(sy_q);
			rb_q <= read_bin;
			oob_q <= 32'(read_bin) >= 32'(lsmrb_pkg::BINS);
		end
		if (state_q == ST_SQ) begin
			dx2_q <= 34'(dx_q) * 34'(dx_q);
			dy2_q <= 34'(dy_q) * 34'(dy_q);
			lim_q <= 24'(srng_q) * 24'(srng_q);
		end
		if (state_q == ST_SUM) d2_q <= 35'(dx2_q) + 35'(dy2_q);
		if (state_q == ST_VEC && cdone) bin_q <= bin_next;
		// digit-by-digit square root, two bits of the radicand per cycle
		if (state_q == ST_RCHK) begin
			rem_q <= rdata_q[DB-1:0];
			root_q <= '0;
			bit_q <= (DB + 1)'(1) << (DB - 2);
		end
		if (state_q == ST_SQRT) begin
			if ((DB + 1)'(rem_q) >= trial) begin
				rem_q <= rem_q - DB'(trial);
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (state_q == ST_GAIN) begin
			rng_q <= 13'(root_q) + 13'((DB + 1)'(rem_q) > root_q);
		end
		// gain product is ready before the rotation starts
		if (state_q == ST_MUL) begin
			prod_q <= 43'(rng_q) * 43'(lsmrb_pkg::GAIN_Q30);
		end
		if (state_q == ST_RCHK) begin
			num_q <= rb_q;
			hit_q <= 1'b0;
			range_q <= '0;
			hx_q <= '0;
			hy_q <= '0;
		end
		if (state_q == ST_ROT && cdone) begin
			hit_q <= 1'b1;
			range_q <= rng_q[11:0];
			hx_q <= sat(sumx);
			hy_q <= sat(sumy);
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign bin_number = num_q;
	assign bin_hit = hit_q;
	assign hit_range = range_q;
	assign hit_x = hx_q;
	assign hit_y = hy_q;

	// assertions
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == ST_RCHK || $past(state_q) == ST_ROT))
		else $error("result strobe from wrong state");
	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == ST_CLR || state_q == ST_UPD))
		else $error("memory write outside clear or update");
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !hit_q) |-> (range_q == 12'd0 && hx_q == '0 && hy_q == '0))
		else $error("empty bin reports data");
	a_busy_result: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy) else $error("strobe while busy");
endmodule
`default_nettype wire

// ----- tb/lidar_scan_min_range_binner_tb.sv -----
// Self-checking testbench for the laser scan min-range binner: directed and random commands.
`default_nettype none
module lidar_scan_min_range_binner_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE = 1100;
	localparam int N_BINS = 1024;
	localparam logic [31:0] ARCTAN [30] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10680350, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1};

	typedef struct {
		logic [1:0] op;
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic [9:0] rb;
	} scan_cmd_t;

	typedef struct {
		logic [9:0] bin;
		logic hit;
		logic [11:0] rng;
		logic signed [15:0] x;
		logic signed [15:0] y;
	} bin_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] op = lsmrb_pkg::OP_CLEAR;
	logic signed [15:0] point_x = '0;
	logic signed [15:0] point_y = '0;
	logic [9:0] read_bin = '0;
	logic wr_en = 1'b0;
	logic [1:0] wr_index = lsmrb_pkg::REG_SENSOR_X;
	logic [15:0] wr_data = '0;
	logic busy, done, bin_hit;
	logic [9:0] bin_number;
	logic [11:0] hit_range;
	logic signed [15:0] hit_x, hit_y;

	lidar_scan_min_range_binner dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.point_x(point_x), .point_y(point_y), .read_bin(read_bin), .done(done),
		.bin_number(bin_number), .bin_hit(bin_hit), .hit_range(hit_range),
		.hit_x(hit_x), .hit_y(hit_y), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data)
	);

	always #10 clk = ~clk;

	// scan state mirror
	logic signed [15:0] pose_x = 0, pose_y = 0;
	logic [11:0] max_range = 12'd320;
	logic occupied [N_BINS];
	logic [23:0] closest_d2 [N_BINS];

	scan_cmd_t pending_cmds[$];
	bin_report_t expected_reports[$];
	int sender_idle_pct = 0;
	int errors = 0, quiet_cycles = 0;
	int n_insert = 0, n_kept = 0, n_read = 0, n_hit = 0, n_clear = 0, n_reports = 0;
	bit word_taken = 0;
	bit [9:0] recent_bins[$];

	function automatic logic [31:0] bearing_of(longint x, longint y);
		logic [31:0] ang;
		longint nx, ny;
		ang = 0;
		if (x == 0 && y == 0)
			return 0;
		x = x * 16384;
		y = y * 16384;
		if (x < 0) begin
			x = -x;
			y = -y;
			ang = 32'h8000_0000;
		end
		for (int i = 0; i < 30; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				ang += ARCTAN[i];
			end else begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				ang -= ARCTAN[i];
			end
			x = nx;
			y = ny;
		end
		return ang;
	endfunction

	function automatic longint sqrt_nearest(longint v);
		longint r, b, rem;
		r = 0;
		b = 64'd1 << 30;
		rem = v;
		while (b > rem)
			b = b >> 2;
		while (b != 0) begin
			if (rem >= r + b) begin
				rem -= r + b;
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		if (v - r * r > r)
			r++;
		return r;
	endfunction

	function automatic logic signed [15:0] clamp16(longint v);
		if (v > 32767)
			return 16'sd32767;
		if (v < -32768)
			return -16'sd32768;
		return v[15:0];
	endfunction

	// rotate range*K by the bin-center angle
	function automatic void bin_center(longint rng, logic [31:0] theta,
			output longint cx, output longint cy);
		longint x, y, z, nx, ny;
		x = ((rng << 16) * 64'd652032874) >> 30;
		y = 0;
		z = theta;
		if (z >= 64'sh8000_0000)
			z -= 64'sh1_0000_0000;
		if (z > 64'sh4000_0000) begin
			x = -x;
			z -= 64'sh8000_0000;
		end else if (z < -64'sh4000_0000) begin
			x = -x;
			z += 64'sh8000_0000;
		end
		for (int i = 0; i < 30; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z -= ARCTAN[i];
			end else begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z += ARCTAN[i];
			end
			x = nx;
			y = ny;
		end
		cx = (x + 32768) >>> 16;
		cy = (y + 32768) >>> 16;
	endfunction

	// apply one command to the mirror; reads queue a report
	function automatic void scan_apply(scan_cmd_t c);
		longint dx, dy, d2, cx, cy;
		logic [63:0] u, b;
		bin_report_t rep;
		case (c.op)
			lsmrb_pkg::OP_CLEAR: begin
				foreach (occupied[i])
					occupied[i] = 1'b0;
				n_clear++;
			end
			lsmrb_pkg::OP_INSERT: begin
				n_insert++;
				dx = longint'(c.px) - longint'(pose_x);
				dy = longint'(c.py) - longint'(pose_y);
				d2 = dx * dx + dy * dy;
				if (d2 <= longint'(max_range) * longint'(max_range)) begin
					n_kept++;
					u = bearing_of(-dx, -dy);
					if (dx == 0 && dy == 0)
						u = 64'h8000_0000;
					b = (u * N_BINS + 64'h8000_0000) >> 32;
					if (b >= N_BINS)
						b = 0;
					if (!occupied[b] || d2 < closest_d2[b]) begin
						occupied[b] = 1'b1;
						closest_d2[b] = d2[23:0];
					end
				end
			end
			lsmrb_pkg::OP_READ: begin
				n_read++;
				rep = '{bin: c.rb, hit: 1'b0, rng: '0, x: '0, y: '0};
				if (occupied[c.rb]) begin
					n_hit++;
					rep.hit = 1'b1;
					cx = sqrt_nearest(closest_d2[c.rb]);
					rep.rng = cx[11:0];
					bin_center(cx, {c.rb, 22'd0} + 32'h8000_0000, cx, cy);
					rep.x = clamp16(cx + pose_x);
					rep.y = clamp16(cy + pose_y);
				end
				expected_reports.insert(expected_reports.size(), rep);
			end
			default: ;
		endcase
	endfunction

	// driver: hold a word until taken, else maybe present the next one
	always @(negedge clk) begin
		scan_cmd_t c;
		if (arst_n && !(start && !word_taken)) begin
			if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				c = pending_cmds.pop_front();
				op <= c.op;
				point_x <= c.px;
				point_y <= c.py;
				read_bin <= c.rb;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: predict on acceptance, check each report
	always @(posedge clk) begin
		bin_report_t e;
		word_taken = start && !busy && arst_n;
		if (word_taken)
			scan_apply('{op: op, px: point_x, py: point_y, rb: read_bin});
		if (arst_n && done) begin
			n_reports++;
			if (expected_reports.size() == 0) begin
				errors++;
				$display("%0t: report for bin %0d with none expected", $realtime, bin_number);
			end else begin
				e = expected_reports.pop_front();
				if (bin_number !== e.bin || bin_hit !== e.hit || hit_range !== e.rng ||
						hit_x !== e.x || hit_y !== e.y) begin
					errors++;
					$display("%0t: mismatch exp bin=%0d hit=%0d rng=%0d x=%0d y=%0d",
						$realtime, e.bin, e.hit, e.rng, e.x, e.y);
					$display("%0t:          got bin=%0d hit=%0d rng=%0d x=%0d y=%0d",
						$realtime, bin_number, bin_hit, hit_range, hit_x, hit_y);
				end
			end
		end
		// watchdog
		if (word_taken || done)
			quiet_cycles = 0;
		else if (arst_n)
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress", $realtime);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic set_reg(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
			lsmrb_pkg::REG_SENSOR_X: pose_x = val;
			lsmrb_pkg::REG_SENSOR_Y: pose_y = val;
			default: max_range = val[11:0];
		endcase
	endtask

	task automatic set_pose(logic [15:0] sx, logic [15:0] sy, logic [11:0] r);
		set_reg(lsmrb_pkg::REG_SENSOR_X, sx);
		set_reg(lsmrb_pkg::REG_SENSOR_Y, sy);
		set_reg(lsmrb_pkg::REG_SENSOR_RANGE, {4'd0, r});
	endtask

	task automatic drain();
		while (pending_cmds.size() != 0 || expected_reports.size() != 0 || start || busy)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic push_cmd(logic [1:0] o, longint x, longint y, logic [9:0] b);
		pending_cmds.insert(pending_cmds.size(),
			scan_cmd_t'{op: o, px: clamp16(x), py: clamp16(y), rb: b});
	endtask

	// insert near the pose, so most land within range
	task automatic push_near();
		int r, dx, dy;
		r = max_range;
		dx = int'($urandom_range(2 * r)) - r;
		dy = int'($urandom_range(2 * r)) - r;
		push_cmd(lsmrb_pkg::OP_INSERT, pose_x + dx, pose_y + dy, '0);
	endtask

	task automatic push_random(int n);
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			if (k < 45)
				push_near();
			else if (k < 52)
				push_cmd(lsmrb_pkg::OP_INSERT, int'($urandom_range(65535)) - 32768,
					int'($urandom_range(65535)) - 32768, 10'($urandom));
			else if (k < 84 && recent_bins.size() != 0)
				push_cmd(lsmrb_pkg::OP_READ, $urandom, $urandom,
					recent_bins[$urandom_range(recent_bins.size() - 1)]);
			else if (k < 97)
				push_cmd(lsmrb_pkg::OP_READ, $urandom, $urandom, 10'($urandom));
			else if (k < 98)
				push_cmd(lsmrb_pkg::OP_CLEAR, $urandom, $urandom, 10'($urandom));
			else
				push_cmd(lsmrb_pkg::OP_UNUSED, $urandom, $urandom, 10'($urandom));
		end
	endtask

	// collect bins occupied now so reads aim at them
	task automatic note_bins();
		recent_bins.delete();
		foreach (occupied[i])
			if (occupied[i])
				recent_bins.insert(recent_bins.size(), 10'(i));
	endtask

	initial begin
		// bins start empty, as after the block's clearing pass
		foreach (occupied[i])
			occupied[i] = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// directed words under reset pose
		push_cmd(lsmrb_pkg::OP_READ, 0, 0, 10'd0);
		push_cmd(lsmrb_pkg::OP_READ, 0, 0, 10'd1023);
		push_cmd(lsmrb_pkg::OP_INSERT, 0, 0, 0);
		push_cmd(lsmrb_pkg::OP_INSERT, 320, 0, 0);
		push_cmd(lsmrb_pkg::OP_INSERT, 321, 0, 0);
		push_cmd(lsmrb_pkg::OP_INSERT, -200, 1, 0);
		push_cmd(lsmrb_pkg::OP_INSERT, -200, -1, 0);
		push_cmd(lsmrb_pkg::OP_INSERT, 0, -100, 0);
		push_cmd(lsmrb_pkg::OP_INSERT, 0, 100, 0);
		push_cmd(lsmrb_pkg::OP_INSERT, 0, 100, 0);
		push_cmd(lsmrb_pkg::OP_INSERT, 0, 50, 0);
		push_cmd(lsmrb_pkg::OP_INSERT, -32768, 32767, 0);
		push_cmd(lsmrb_pkg::OP_UNUSED, -1, -1, 10'h3ff);
		push_cmd(lsmrb_pkg::OP_READ, 0, 0, 10'd0);
		push_cmd(lsmrb_pkg::OP_READ, 0, 0, 10'd512);
		push_cmd(lsmrb_pkg::OP_READ, 0, 0, 10'd256);
		push_cmd(lsmrb_pkg::OP_READ, 0, 0, 10'd768);
		push_cmd(lsmrb_pkg::OP_READ, 0, 0, 10'd1023);
		push_cmd(lsmrb_pkg::OP_CLEAR, 0, 0, 0);
		push_cmd(lsmrb_pkg::OP_READ, 0, 0, 10'd768);
		drain();

		// saturation at the coordinate edges
		set_pose(16'h7fff, 16'h8000, 12'd4095);
		push_cmd(lsmrb_pkg::OP_INSERT, 32767, -32768 + 4095, 0);
		push_cmd(lsmrb_pkg::OP_INSERT, 32767 - 4095, -32768, 0);
		push_cmd(lsmrb_pkg::OP_READ, 0, 0, 10'd768);
		push_cmd(lsmrb_pkg::OP_READ, 0, 0, 10'd0);
		push_cmd(lsmrb_pkg::OP_READ, 0, 0, 10'd512);
		drain();

		// random phases over several poses and sender idle rates
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: set_pose(0, 0, 12'd4095);
				1: set_pose(16'h7fff, 16'h8000, 12'd4095);
				2: set_pose(16'h8000, 16'h7fff, 12'd1);
				3: set_pose(16'($urandom), 16'($urandom), 12'd0);
				default: set_pose(16'($urandom), 16'($urandom), 12'($urandom_range(4095)));
			endcase
			sender_idle_pct = (p % 4 == 1) ? 72 : ((p % 4 == 3) ? 8 : 0);
			for (int j = 0; j < 60; j++)
				push_near();
			drain();
			note_bins();
			push_random(168);
			drain();
		end

		$display("words: %0d inserts (%0d in range), %0d reads (%0d hits), %0d clears",
			n_insert, n_kept, n_read, n_hit, n_clear);
		$display("reports checked: %0d, errors: %0d", n_reports, errors);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire

// ----- lidar_scan_min_range_binner.f -----
rtl/lsmrb_pkg.sv
rtl/lsmrb_cordic.sv
rtl/lidar_scan_min_range_binner.sv
tb/lidar_scan_min_range_binner_tb.sv
